// ===== hdl/cbts_pkg.sv =====
// types and constants shared by the can bit timing search modules
package cbts_pkg;

    localparam int RATE_W  = 20;
    localparam int OSC_W   = 26;
    localparam int SJW_W   = 3;
    localparam int PROP_W  = 4;
    localparam int TDEL_W  = 2;
    localparam int SEG_W   = 8;
    localparam int TOT_W   = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_SJW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PROP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TDELAY = 2'd2;

    typedef struct packed {
        logic [RATE_W-1:0] bit_rate;
        logic [OSC_W-1:0]  osc_freq;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [5:0]  prescaler;
        logic [7:0]  quanta_per_bit;
        logic [2:0]  jump_width;
        logic [3:0]  prop_len;
        logic [4:0]  phase1_len;
        logic [5:0]  phase2_len;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic b_init;
        logic b_next;
        logic div_load;
        logic div_step;
        logic hit;
        logic seg_init;
        logic shrink;
        logic grow;
        logic found_set;
    } dp_cmd_t;

    typedef struct packed {
        logic rate_zero;
        logic too_big;
        logic div_last;
        logic div_hit;
        logic b_last;
        logic can_shrink;
        logic pass_ok;
        logic stop_after;
    } dp_stat_t;

endpackage

// ===== hdl/cbts_ctrl.sv =====
// controller state machine of the can bit timing search
module cbts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cbts_pkg::dp_stat_t stat,
    output cbts_pkg::dp_cmd_t  cmd,
    output logic               busy,
    output logic               done
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PINIT  = 4'd1;
    localparam logic [3:0] ST_PCHK   = 4'd2;
    localparam logic [3:0] ST_PDIV   = 4'd3;
    localparam logic [3:0] ST_PEVAL  = 4'd4;
    localparam logic [3:0] ST_SINIT  = 4'd5;
    localparam logic [3:0] ST_SHRINK = 4'd6;
    localparam logic [3:0] ST_TEST   = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_PINIT;
                end
            end
            ST_PINIT:
            begin
                cmd.b_init = 1'b1;
                state_next = stat.rate_zero ? ST_SINIT : ST_PCHK;
            end
            ST_PCHK:
            begin
                if (stat.too_big)
                begin
                    cmd.b_next = 1'b1;
                    state_next = stat.b_last ? ST_SINIT : ST_PCHK;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_PEVAL;
                end
            end
            ST_PEVAL:
            begin
                if (stat.div_hit)
                begin
                    cmd.hit = 1'b1;
                    state_next = ST_SINIT;
                end
                else
                begin
                    cmd.b_next = 1'b1;
                    state_next = stat.b_last ? ST_SINIT : ST_PCHK;
                end
            end
            ST_SINIT:
            begin
                cmd.seg_init = 1'b1;
                state_next = ST_SHRINK;
            end
            ST_SHRINK:
            begin
                if (stat.can_shrink)
                begin
                    cmd.shrink = 1'b1;
                end
                else
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (stat.pass_ok)
                begin
                    cmd.found_set = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.grow = 1'b1;
                    if (stat.stop_after)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

// ===== hdl/cbts_dp.sv =====
// datapath of the can bit timing search: prescaler divider and segment registers
module cbts_dp #(
    parameter int PRESCALER_LIMIT = 63,
    parameter int SEARCH_PASSES   = 30
) (
    input  logic                         clk,
    input  cbts_pkg::dp_cmd_t            cmd,
    input  cbts_pkg::in_item_t           in_item,
    input  logic [cbts_pkg::SJW_W-1:0]   cfg_sjw,
    input  logic [cbts_pkg::PROP_W-1:0]  cfg_prop,
    input  logic [cbts_pkg::TDEL_W-1:0]  cfg_tdel,
    output cbts_pkg::dp_stat_t           stat,
    output cbts_pkg::out_item_t          result
);

    localparam int BW = $clog2(PRESCALER_LIMIT + 1);
    localparam int DW = cbts_pkg::RATE_W + BW + 1;
    localparam int SW = DW + 7;
    localparam int PW = $clog2(SEARCH_PASSES + 1);
    localparam int RW = cbts_pkg::OSC_W;
    localparam int TW = cbts_pkg::TOT_W;

    logic [cbts_pkg::RATE_W-1:0] rate_reg;
    logic [RW-1:0]               osc_reg;
    logic [BW-1:0]               b_reg;
    logic [DW-1:0]               d_reg;
    logic [SW-1:0]               ds_reg;
    logic [RW-1:0]               rem_reg;
    logic [7:0]                  q_reg;
    logic [2:0]                  cnt_reg;
    logic [BW-1:0]               presc_reg;
    logic [7:0]                  tbit_reg;
    logic [cbts_pkg::SJW_W-1:0]  sjw_reg;
    logic [cbts_pkg::PROP_W-1:0] prop_reg;
    logic [cbts_pkg::TDEL_W-1:0] tdel_reg;
    logic [cbts_pkg::SEG_W-1:0]  ps1_reg;
    logic [cbts_pkg::SEG_W-1:0]  ps2_reg;
    logic [PW-1:0]               pass_reg;
    logic                        found_reg;

    logic [DW-1:0]  rate2;
    logic [DW+8:0]  d_hi;
    logic           rem_ge;
    logic [TW-1:0]  c1, c2, total, tbit_x;
    logic [17:0]    c2_100, tot_59, tot_71;
    logic signed [15:0] t1, a1, a2, e1, e2;

    assign rate2 = {{(DW-cbts_pkg::RATE_W-1){1'b0}}, rate_reg, 1'b0};
    assign d_hi  = {1'b0, d_reg, 8'd0};
    assign rem_ge = ({{(SW-RW){1'b0}}, rem_reg} >= ds_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rate_reg <= in_item.bit_rate;
            osc_reg  <= in_item.osc_freq;
            presc_reg <= '0;
            tbit_reg  <= '0;
        end
        if (cmd.b_init)
        begin
            b_reg <= BW'(1);
            d_reg <= rate2;
        end
        if (cmd.b_next)
        begin
            b_reg <= b_reg + BW'(1);
            d_reg <= d_reg + rate2;
        end
        if (cmd.div_load)
        begin
            rem_reg <= osc_reg;
            ds_reg  <= {d_reg, 7'd0};
            q_reg   <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - ds_reg[RW-1:0];
            end
            q_reg   <= {q_reg[6:0], rem_ge};
            ds_reg  <= ds_reg >> 1;
            cnt_reg <= cnt_reg + 3'd1;
        end
        if (cmd.hit)
        begin
            presc_reg <= b_reg;
            tbit_reg  <= q_reg;
        end
        if (cmd.seg_init)
        begin
            sjw_reg   <= cfg_sjw;
            prop_reg  <= cfg_prop;
            tdel_reg  <= cfg_tdel;
            ps1_reg   <= '0;
            ps2_reg   <= {{(cbts_pkg::SEG_W-cbts_pkg::SJW_W){1'b0}}, cfg_sjw}
                         + cbts_pkg::SEG_W'(1);
            pass_reg  <= PW'(SEARCH_PASSES);
            found_reg <= 1'b0;
        end
        if (cmd.shrink)
        begin
            if (tdel_reg > 2'd1)
            begin
                tdel_reg <= tdel_reg - 2'd1;
            end
            else if (prop_reg > 4'd1)
            begin
                prop_reg <= prop_reg - 4'd1;
            end
            else
            begin
                sjw_reg <= sjw_reg - 3'd1;
                if (ps2_reg > {{(cbts_pkg::SEG_W-cbts_pkg::SJW_W){1'b0}}, sjw_reg})
                begin
                    ps2_reg <= ps2_reg - cbts_pkg::SEG_W'(1);
                end
            end
        end
        if (cmd.grow)
        begin
            if (e1 < e2)
            begin
                ps1_reg <= ps1_reg + cbts_pkg::SEG_W'(1);
            end
            else
            begin
                ps2_reg <= ps2_reg + cbts_pkg::SEG_W'(1);
            end
            pass_reg <= pass_reg - PW'(1);
        end
        if (cmd.found_set)
        begin
            found_reg <= 1'b1;
        end
    end

    // segment sums and the sample point window
    assign c1     = TW'(prop_reg) + TW'(ps1_reg);
    assign c2     = c1 + TW'(1);
    assign total  = c2 + TW'(ps2_reg);
    assign tbit_x = TW'(tbit_reg);
    assign c2_100 = 18'(c2) * 18'd100;
    assign tot_59 = 18'(total) * 18'd59;
    assign tot_71 = 18'(total) * 18'd71;
    assign t1 = 16'(total + TW'(1)) * 16'sd13;
    assign a1 = 16'(c2 + TW'(1)) * 16'sd20 - t1;
    assign a2 = 16'(c2) * 16'sd20 - t1;
    assign e1 = a1[15] ? -a1 : a1;
    assign e2 = a2[15] ? -a2 : a2;

    always_comb
    begin
        stat.rate_zero  = (rate_reg == '0);
        stat.too_big    = ({{(DW+9-RW){1'b0}}, osc_reg} >= d_hi);
        stat.div_last   = (cnt_reg == 3'd7);
        stat.div_hit    = (rem_reg == '0) && (q_reg != 8'd0);
        stat.b_last     = (b_reg == BW'(PRESCALER_LIMIT));
        stat.can_shrink = (tbit_x < total)
                          && ((tdel_reg > 2'd1) || (prop_reg > 4'd1) || (sjw_reg > 3'd1));
        stat.pass_ok    = (c1 >= TW'(ps2_reg)) && (c2_100 > tot_59) && (c2_100 < tot_71)
                          && (c1 >= TW'(tdel_reg)) && (total == tbit_x);
        stat.stop_after = (pass_reg == PW'(1)) || (total > tbit_x);
    end

    always_comb
    begin
        result.found          = found_reg;
        result.prescaler      = 6'(presc_reg);
        result.quanta_per_bit = tbit_reg;
        result.jump_width     = sjw_reg;
        result.prop_len       = prop_reg;
        result.phase1_len     = ps1_reg[4:0];
        result.phase2_len     = ps2_reg[5:0];
    end

endmodule

// ===== hdl/can_bit_timing_search.sv =====
// top level of the can bit timing search: config registers, controller, datapath
//
// usage
//   command channel: drive in_item and raise start; the item is taken at an
//   edge where start is high and busy is low. busy stays high until the
//   result is shown.
//   result channel: out_item is valid for exactly one cycle while done is
//   high; the receiver cannot stall it and must take it in that cycle.
//   config channel: cfg_valid with cfg_index and cfg_data; cfg_ready is
//   always high. index 0 start_sjw, 1 start_prop_seg, 2 start_tdelay;
//   other indexes are ignored. write only while busy is low.
// search
//   the prescaler scan skips each prescaler whose quotient would exceed
//   255, else runs an 8 step restoring divider and then checks the result.
//   segment search: shrink steps, then adjust passes; up to 22 shrink
//   steps at the largest start values; one item at a time.
// reset
//   rst_n clears the controller to idle and loads the register defaults
//   (sjw 1, propagation 2, tdelay 1); no result is pending after reset.
module can_bit_timing_search #(
    parameter int PRESCALER_LIMIT = 63,
    parameter int SEARCH_PASSES   = 30
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  cbts_pkg::in_item_t                in_item,
    output logic                              done,
    output cbts_pkg::out_item_t               out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data
);

    logic [cbts_pkg::SJW_W-1:0]  sjw_cfg_reg;
    logic [cbts_pkg::PROP_W-1:0] prop_cfg_reg;
    logic [cbts_pkg::TDEL_W-1:0] tdel_cfg_reg;

    cbts_pkg::dp_cmd_t  cmd;
    cbts_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    // configuration registers, masked to field width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sjw_cfg_reg  <= 3'd1;
            prop_cfg_reg <= 4'd2;
            tdel_cfg_reg <= 2'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cbts_pkg::CFG_START_SJW:    sjw_cfg_reg  <= cfg_data[2:0];
                cbts_pkg::CFG_START_PROP:   prop_cfg_reg <= cfg_data[3:0];
                cbts_pkg::CFG_START_TDELAY: tdel_cfg_reg <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer for prescaler scan, shrink steps and adjust passes
    cbts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // divider, segment registers and pass tests
    cbts_dp #(
        .PRESCALER_LIMIT (PRESCALER_LIMIT),
        .SEARCH_PASSES   (SEARCH_PASSES)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .in_item  (in_item),
        .cfg_sjw  (sjw_cfg_reg),
        .cfg_prop (prop_cfg_reg),
        .cfg_tdel (tdel_cfg_reg),
        .stat     (stat),
        .result   (out_item)
    );

endmodule

// ===== sim/tb_can_bit_timing_search.sv =====
// testbench for the can bit timing search: random and directed items against an inline predictor
`timescale 1ns / 1ps

module tb_can_bit_timing_search;

    localparam int PRESC_MAX  = 63;
    localparam int PASS_MAX   = 30;
    localparam int IDLE_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cbts_pkg::in_item_t   in_item;
    logic                 done;
    cbts_pkg::out_item_t  out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [cbts_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // predictor copy of the config registers
    logic [2:0] sjw_reg;
    logic [3:0] prop_reg;
    logic [1:0] tdel_reg;

    cbts_pkg::in_item_t  pending_items[$];
    cbts_pkg::out_item_t timing_expected[$];
    int        err_count;
    int        idle_cycles;
    bit        hold_off;    // sender waits until all results are back
    int        burst_left;
    int        gap_left;
    logic      accepted_last;

    can_bit_timing_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .done      (done),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // bit timing predictor: prescaler scan, shrink on first pass, grow toward 0.65
    function automatic cbts_pkg::out_item_t predict_timing(cbts_pkg::in_item_t it);
        longint    rate;
        longint    osc;
        longint    d;
        longint    t1;
        longint    e1;
        longint    e2;
        int        presc;
        int        tbit;
        int        sjw;
        int        prop;
        int        tdel;
        int        ps1;
        int        ps2;
        int        c1;
        int        c2;
        int        total;
        int        passes;
        bit        ok;
        cbts_pkg::out_item_t r;
        rate   = it.bit_rate;
        osc    = it.osc_freq;
        presc  = 0;
        tbit   = 0;
        sjw    = sjw_reg;
        prop   = prop_reg;
        tdel   = tdel_reg;
        ps1    = 0;
        ps2    = 0;
        ok     = 1'b0;
        passes = PASS_MAX;
        if (rate != 0)
        begin
            for (int b = 1; b <= PRESC_MAX; b++)
            begin
                d = 2 * b * rate;
                if (osc % d == 0 && osc / d >= 1 && osc / d <= 255)
                begin
                    presc = b;
                    tbit  = int'(osc / d);
                    break;
                end
            end
        end
        while (ps2 <= sjw)
            ps2++;
        while (passes > 0 && !ok)
        begin
            c1    = prop + ps1;
            c2    = 1 + c1;
            total = c2 + ps2;
            if (passes == PASS_MAX)
            begin
                while (tbit < total)
                begin
                    if (tdel > 1)
                        tdel--;
                    else if (prop > 1)
                        prop--;
                    else if (sjw > 1)
                    begin
                        sjw--;
                        if (ps2 > sjw + 1)
                            ps2--;
                    end
                    else
                        break;
                    c1    = prop + ps1;
                    c2    = 1 + c1;
                    total = c2 + ps2;
                end
            end
            if (c1 >= ps2 && 100 * c2 > 59 * total && 100 * c2 < 71 * total
                && c1 >= tdel && total == tbit)
                ok = 1'b1;
            if (!ok)
            begin
                t1 = 13 * (longint'(total) + 1);
                e1 = 20 * (longint'(c2) + 1) - t1;
                e2 = 20 * longint'(c2) - t1;
                if (e1 < 0)
                    e1 = -e1;
                if (e2 < 0)
                    e2 = -e2;
                if (e1 < e2)
                    ps1++;
                else
                    ps2++;
            end
            passes--;
            if (total > tbit)
                passes = 0;
        end
        r.found          = ok;
        r.prescaler      = presc[5:0];
        r.quanta_per_bit = tbit[7:0];
        r.jump_width     = sjw[2:0];
        r.prop_len       = prop[3:0];
        r.phase1_len     = ps1[4:0];
        r.phase2_len     = ps2[5:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    // driver: bursts of items with random gaps, start held until the item is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || accepted_last)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (pending_items.size() > 0
                         && !(hold_off && (timing_expected.size() > 0 || busy)))
                begin
                    in_item <= pending_items.pop_front();
                    start   <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(8, 1);
                        gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // item acceptance seen at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_last <= 1'b0;
        end
        else
        begin
            accepted_last <= start && !busy;
            if (start && !busy)
                timing_expected.push_back(predict_timing(in_item));
        end
    end

    // monitor: results cannot be stalled and are checked in the done cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                if (timing_expected.size() == 0)
                begin
                    $display("mismatch: result with nothing expected");
                    err_count++;
                end
                else
                begin
                    cbts_pkg::out_item_t w;
                    w = timing_expected.pop_front();
                    if (out_item.found !== w.found)
                        report_mismatch("found", int'(out_item.found), int'(w.found));
                    if (out_item.prescaler !== w.prescaler)
                        report_mismatch("prescaler", int'(out_item.prescaler),
                                        int'(w.prescaler));
                    if (out_item.quanta_per_bit !== w.quanta_per_bit)
                        report_mismatch("quanta_per_bit", int'(out_item.quanta_per_bit),
                                        int'(w.quanta_per_bit));
                    if (out_item.jump_width !== w.jump_width)
                        report_mismatch("jump_width", int'(out_item.jump_width),
                                        int'(w.jump_width));
                    if (out_item.prop_len !== w.prop_len)
                        report_mismatch("prop_len", int'(out_item.prop_len),
                                        int'(w.prop_len));
                    if (out_item.phase1_len !== w.phase1_len)
                        report_mismatch("phase1_len", int'(out_item.phase1_len),
                                        int'(w.phase1_len));
                    if (out_item.phase2_len !== w.phase2_len)
                        report_mismatch("phase2_len", int'(out_item.phase2_len),
                                        int'(w.phase2_len));
                end
            end
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // item whose rate divides the oscillator cleanly with a chosen prescaler and quanta
    function automatic cbts_pkg::in_item_t make_clean(int presc, int tq);
        cbts_pkg::in_item_t it;
        longint   r;
        longint   lim;
        lim = 67108863 / (2 * presc * tq);
        if (lim > 1000000)
            lim = 1000000;
        if (lim < 1)
            lim = 1;
        r = $urandom_range(int'(lim), 1);
        it.bit_rate = r[19:0];
        it.osc_freq = 26'(2 * presc * tq * r);
        return it;
    endfunction

    function automatic cbts_pkg::in_item_t make_raw(logic [19:0] r, logic [25:0] o);
        cbts_pkg::in_item_t it;
        it.bit_rate = r;
        it.osc_freq = o;
        return it;
    endfunction

    task automatic write_reg(input logic [cbts_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            cbts_pkg::CFG_START_SJW:    sjw_reg  = val[2:0];
            cbts_pkg::CFG_START_PROP:   prop_reg = val[3:0];
            cbts_pkg::CFG_START_TDELAY: tdel_reg = val[1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until the block is idle with nothing outstanding
    task automatic drain();
        while (pending_items.size() > 0 || timing_expected.size() > 0 || start || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic fill_random(input int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(9, 0);
            if (k < 7)
                pending_items.push_back(make_clean($urandom_range(PRESC_MAX, 1),
                                                   $urandom_range(255, 1)));
            else if (k == 7)
                pending_items.push_back(make_raw(20'($urandom), 26'($urandom)));
            else
                pending_items.push_back(make_clean($urandom_range(PRESC_MAX, 1),
                                                   $urandom_range(40, 4)));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        in_item     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        err_count   = 0;
        idle_cycles = 0;
        hold_off    = 0;
        burst_left  = 0;
        gap_left    = 0;
        sjw_reg     = 3'd1;
        prop_reg    = 4'd2;
        tdel_reg    = 2'd1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, no-prescaler, zero inputs, too-large quotients
        pending_items.push_back(make_raw(20'd0, 26'd0));
        pending_items.push_back(make_raw(20'd0, 26'h3FFFFFF));
        pending_items.push_back(make_raw(20'd1, 26'd0));
        pending_items.push_back(make_raw(20'hFFFFF, 26'h3FFFFFF));
        pending_items.push_back(make_raw(20'd1, 26'h3FFFFFF));
        pending_items.push_back(make_raw(20'd125000, 26'd16000000));
        pending_items.push_back(make_raw(20'd500000, 26'd8000000));
        pending_items.push_back(make_raw(20'd1000000, 26'd2000000));
        pending_items.push_back(make_raw(20'd1, 26'd512));
        pending_items.push_back(make_raw(20'd1, 26'd510));
        pending_items.push_back(make_raw(20'd1, 26'd32130));
        pending_items.push_back(make_raw(20'd1, 26'd126));
        pending_items.push_back(make_raw(20'd1, 26'd4));
        pending_items.push_back(make_raw(20'd3, 26'd18));
        pending_items.push_back(make_raw(20'd100000, 26'd20000000));
        pending_items.push_back(make_raw(20'd250000, 26'd40000000));
        pending_items.push_back(make_raw(20'h55555, 26'h2AAAAAA));
        pending_items.push_back(make_raw(20'hAAAAA, 26'h1555555));
        pending_items.push_back(make_clean(1, 255));
        pending_items.push_back(make_clean(63, 1));
        drain();

        // settings sweep including register extremes and out-of-range values
        write_reg(cbts_pkg::CFG_START_SJW, 8'd4);
        write_reg(cbts_pkg::CFG_START_PROP, 8'd8);
        write_reg(cbts_pkg::CFG_START_TDELAY, 8'd2);
        fill_random(40);
        drain();
        write_reg(cbts_pkg::CFG_START_SJW, 8'd7);
        write_reg(cbts_pkg::CFG_START_PROP, 8'd15);
        write_reg(cbts_pkg::CFG_START_TDELAY, 8'd3);
        fill_random(40);
        hold_off = 1;
        drain();
        hold_off = 0;
        write_reg(cbts_pkg::CFG_START_SJW, 8'd0);
        write_reg(cbts_pkg::CFG_START_PROP, 8'd0);
        write_reg(cbts_pkg::CFG_START_TDELAY, 8'd0);
        fill_random(30);
        drain();
        write_reg(cbts_pkg::CFG_START_SJW, 8'hF9);
        write_reg(cbts_pkg::CFG_START_PROP, 8'hF1);
        write_reg(cbts_pkg::CFG_START_TDELAY, 8'hFD);
        write_reg(2'd3, 8'hFF);
        fill_random(30);
        drain();
        for (int ph = 0; ph < 3; ph++)
        begin
            write_reg(cbts_pkg::CFG_START_SJW, 8'($urandom_range(4, 1)));
            write_reg(cbts_pkg::CFG_START_PROP, 8'($urandom_range(8, 1)));
            write_reg(cbts_pkg::CFG_START_TDELAY, 8'($urandom_range(2, 1)));
            fill_random(43);
            drain();
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
